FILE: rtl/core/indexed_binary_heap_queue_defines.svh
// assertion helpers, sampled on clk and disabled during rst
`ifndef INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_BINARY_HEAP_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define IBHQ_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define IBHQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define IBHQ_ASSERT(lbl, expr, msg)
`define IBHQ_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ibhq_pkg.sv
`default_nettype none
package ibhq_pkg;
  localparam int TAG_W = 6;
  localparam int TAG_SPACE = 64;
  localparam int IN_KEY_W = 32;
  localparam int CNT_OUT_W = 7;
  localparam int IN_W = 40;
  localparam int OUT_W = 88;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_PULL   = 2'd1,
    REQ_ADJUST = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/core/ibhq_heap_mem.sv
`default_nettype none
module ibhq_heap_mem import ibhq_pkg::*; #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_BITS = 32,
  parameter int PW = 6
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [PW-1:0]         wr_addr,
  input  wire logic [KEY_BITS-1:0]   wr_key,
  input  wire logic [TAG_W-1:0]      wr_tag,
  input  wire logic [PW-1:0]         rd_addr_a,
  input  wire logic [PW-1:0]         rd_addr_b,
  output logic      [KEY_BITS-1:0]   rd_key_a,
  output logic      [TAG_W-1:0]      rd_tag_a,
  output logic      [KEY_BITS-1:0]   rd_key_b,
  output logic      [TAG_W-1:0]      rd_tag_b
);
  logic [KEY_BITS+TAG_W-1:0] mem [HEAP_DEPTH];

  // slot = {tag, key}
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_key};
    end
    {rd_tag_a, rd_key_a} <= mem[rd_addr_a];
    {rd_tag_b, rd_key_b} <= mem[rd_addr_b];
  end
endmodule
`default_nettype wire

FILE: rtl/core/ibhq_tag_map.sv
`default_nettype none
module ibhq_tag_map import ibhq_pkg::*; #(
  parameter int PW = 6
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [TAG_W-1:0]   wr_tag,
  input  wire logic [PW-1:0]      wr_pos,
  input  wire logic [TAG_W-1:0]   rd_tag,
  output logic      [PW-1:0]      rd_pos
);
  logic [PW-1:0] mem [TAG_SPACE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_tag] <= wr_pos;
    end
    rd_pos <= mem[rd_tag];
  end
endmodule
`default_nettype wire

FILE: rtl/core/indexed_binary_heap_queue.sv
// from accept: request states, a read/compare pair per level walked, S_TOP_RD, S_TOP_CAP
// a sift walks at most clog2(HEAP_DEPTH) levels
// throughput: one item at a time, input ready again the cycle after the result is registered
// a result still held by m_axis_tready stalls the next item only at its final stage
// reset: entry count and order mode clear; heap and tag map contents stay unknown
`default_nettype none
`include "indexed_binary_heap_queue_defines.svh"
module indexed_binary_heap_queue import ibhq_pkg::*; #(
  parameter int HEAP_DEPTH = 64,
  parameter int KEY_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // req_type[1:0], key[33:2], tag[39:34]
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // status[1:0], removed_key[33:2], removed_tag[39:34], top_key[71:40],
  // top_tag[77:72], count[84:78], zero pad[87:85]
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata
);
  localparam int PW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int NW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MAP_RD, S_ADJ_RD, S_ADJ_CMP, S_RISE_RD, S_RISE_CMP,
    S_SINK_RD, S_SINK_CMP, S_PULL_RD, S_PULL_CMP, S_TOP_RD, S_TOP_CAP
  } state_t;

  state_t                state;
  logic                  order_mode;
  logic [CW-1:0]         count;
  logic [PW-1:0]         pos;        // hole position of the moving entry
  logic [KEY_BITS-1:0]   cur_key;    // entry being sifted
  logic [TAG_W-1:0]      cur_tag;
  logic [TAG_W-1:0]      req_tag;
  status_t               status;
  logic [KEY_BITS-1:0]   rem_key;
  logic [TAG_W-1:0]      rem_tag;
  logic [84:0]           out_data;
  logic                  out_valid;

  // input field split
  logic [1:0]            in_req;
  logic [IN_KEY_W-1:0]   in_key;
  logic [TAG_W-1:0]      in_tag;
  logic [KEY_BITS-1:0]   in_key_m;
  assign in_req   = s_axis_tdata[1:0];
  assign in_key   = s_axis_tdata[33:2];
  assign in_tag   = s_axis_tdata[39:34];
  assign in_key_m = KEY_BITS'(64'(in_key));

  // memory ports
  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [TAG_W-1:0]      wr_tag;
  logic [PW-1:0]         rd_addr_a, rd_addr_b;
  logic [KEY_BITS-1:0]   key_a, key_b;
  logic [TAG_W-1:0]      tag_a, tag_b;
  logic [PW-1:0]         map_pos;

  ibhq_heap_mem #(.HEAP_DEPTH(HEAP_DEPTH), .KEY_BITS(KEY_BITS), .PW(PW)) u_heap (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key), .wr_tag(wr_tag),
    .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
    .rd_key_a(key_a), .rd_tag_a(tag_a), .rd_key_b(key_b), .rd_tag_b(tag_b)
  );

  // every heap write also moves the tag's map entry to the written slot
  ibhq_tag_map #(.PW(PW)) u_map (
    .clk(clk), .wr_en(wr_en), .wr_tag(wr_tag), .wr_pos(wr_addr),
    .rd_tag(req_tag), .rd_pos(map_pos)
  );

  function automatic logic outranks(input logic om, input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    outranks = om ? (a < b) : (a > b);
  endfunction

  // heap geometry
  logic [PW-1:0]   up_pos;
  logic [NW-1:0]   lchild, rchild, count_w;
  logic            at_leaf, right_ok, pick_right;
  logic [KEY_BITS-1:0] best_key;
  logic [TAG_W-1:0]    best_tag;
  logic [PW-1:0]       best_pos;
  logic [PW-1:0]       map_up;
  logic            present;

  assign up_pos   = (pos - PW'(1)) >> 1;
  assign lchild   = NW'({pos, 1'b1});
  assign rchild   = lchild + NW'(1);
  assign count_w  = NW'(count);
  assign at_leaf  = (lchild >= count_w);
  assign right_ok = (rchild < count_w);
  assign pick_right = right_ok && outranks(order_mode, key_b, key_a);
  assign best_key = pick_right ? key_b : key_a;
  assign best_tag = pick_right ? tag_b : tag_a;
  assign best_pos = pick_right ? rchild[PW-1:0] : lchild[PW-1:0];
  assign map_up   = (map_pos - PW'(1)) >> 1;
  // map entry may be stale or never written: check range, then the slot's tag
  assign present  = (NW'(map_pos) < count_w) && (tag_a == req_tag);

  // read addresses and the single write port, decoded from state
  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_key    = cur_key;
    wr_tag    = cur_tag;
    unique case (state)
      S_ADJ_RD: begin
        rd_addr_a = map_pos;
        rd_addr_b = map_up;
      end
      S_RISE_RD: begin
        rd_addr_a = up_pos;
        wr_en     = (pos == '0);
      end
      S_RISE_CMP: begin
        wr_en = 1'b1;
        if (outranks(order_mode, cur_key, key_a)) begin
          wr_key = key_a;
          wr_tag = tag_a;
        end
      end
      S_SINK_RD: begin
        rd_addr_a = lchild[PW-1:0];
        rd_addr_b = rchild[PW-1:0];
        wr_en     = at_leaf;
      end
      S_SINK_CMP: begin
        wr_en = 1'b1;
        if (outranks(order_mode, best_key, cur_key)) begin
          wr_key = best_key;
          wr_tag = best_tag;
        end
      end
      S_PULL_RD: begin
        rd_addr_b = PW'(count - CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      order_mode <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_mode <= cfg_wdata;
      end
      // the capture stage below sets the flag itself when it takes the free slot
      if (out_valid && m_axis_tready && (state != S_TOP_CAP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cur_key <= in_key_m;
            cur_tag <= in_tag;
            req_tag <= in_tag;
            status  <= ST_OK;
            rem_key <= '0;
            rem_tag <= '0;
            state   <= S_TOP_RD;
            unique case (in_req)
              REQ_PUSH: begin
                if (count >= CW'(HEAP_DEPTH)) begin
                  status <= ST_FULL;
                end else begin
                  pos   <= count[PW-1:0];
                  count <= count + CW'(1);
                  state <= S_RISE_RD;
                end
              end
              REQ_PULL: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  state <= S_PULL_RD;
                end
              end
              REQ_ADJUST: state <= S_MAP_RD;
              default:    state <= S_TOP_RD;
            endcase
          end
        end
        S_MAP_RD: state <= S_ADJ_RD;
        S_ADJ_RD: state <= S_ADJ_CMP;
        S_ADJ_CMP: begin
          pos <= map_pos;
          if (!present) begin
            state <= S_TOP_RD;
          end else if (map_pos != '0 && outranks(order_mode, cur_key, key_b)) begin
            state <= S_RISE_RD;
          end else begin
            state <= S_SINK_RD;
          end
        end
        S_RISE_RD: begin
          state <= (pos == '0) ? S_TOP_RD : S_RISE_CMP;
        end
        S_RISE_CMP: begin
          if (outranks(order_mode, cur_key, key_a)) begin
            pos   <= up_pos;
            state <= S_RISE_RD;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_SINK_RD: begin
          state <= at_leaf ? S_TOP_RD : S_SINK_CMP;
        end
        S_SINK_CMP: begin
          if (outranks(order_mode, best_key, cur_key)) begin
            pos   <= best_pos;
            state <= S_SINK_RD;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_PULL_RD: state <= S_PULL_CMP;
        S_PULL_CMP: begin
          // root leaves, last entry sinks from the root
          rem_key <= key_a;
          rem_tag <= tag_a;
          count   <= count - CW'(1);
          cur_key <= key_b;
          cur_tag <= tag_b;
          pos     <= '0;
          state   <= (count == CW'(1)) ? S_TOP_RD : S_SINK_RD;
        end
        S_TOP_RD: state <= S_TOP_CAP;
        S_TOP_CAP: begin
          // wait here while the previous result is still unread
          if (!out_valid || m_axis_tready) begin
            out_data <= {CNT_OUT_W'(count),
                         (count != '0) ? tag_a : TAG_W'(0),
                         (count != '0) ? IN_KEY_W'(64'(key_a)) : IN_KEY_W'(0),
                         rem_tag, IN_KEY_W'(64'(rem_key)), status};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_data};

  logic in_sift;
  assign in_sift = (state == S_RISE_RD) || (state == S_RISE_CMP) ||
                   (state == S_SINK_RD) || (state == S_SINK_CMP);

  `IBHQ_ASSERT(a_count_range, NW'(count) <= NW'(HEAP_DEPTH), "entry count above depth")
  `IBHQ_ASSERT_IMPL(a_write_in_heap, wr_en, NW'(wr_addr) < count_w, "heap write beyond count")
  `IBHQ_ASSERT_IMPL(a_sift_nonempty, in_sift, count != '0, "sift with empty heap")
endmodule
`default_nettype wire
